FILE: hw/rtl/swtm_pkg.sv
// Shared types and constants for the sliding-window trimmed mean block.
// No dependencies.
package swtm_pkg;
    localparam int WindowMax   = 64;
    localparam int SampleBits  = 16;
    localparam int AddrBits    = $clog2(WindowMax);
    localparam int CountBits   = $clog2(WindowMax + 1);
    localparam int SumBits     = SampleBits + AddrBits;
    localparam int LenBits     = 7;
    localparam int TrimBits    = 5;

    localparam logic [0:0] RegWindowLen = 1'b0;
    localparam logic [0:0] RegTrimCount = 1'b1;

    typedef struct packed {
        logic                  start;
        logic [SumBits-1:0]    dividend;
        logic [CountBits-1:0]  divisor;
    } div_req_t;
endpackage

FILE: hw/rtl/sliding_window_trimmed_mean_top.sv
// Top level of the sliding-window trimmed mean: stream ports, config
// registers, output register. Depends on swtm_pkg, swtm_window, swtm_divider.
//
// One 16-bit sample is taken per transfer and one result returned. Samples
// live in a ring memory and a sorted memory; each sample scans and shifts
// the sorted memory one entry a cycle, then, when the window is full, sums
// the middle ranks and runs a restoring divide; the sorted memory has a
// single read port. A new sample is taken only once the previous result
// has left, or is leaving, the output register. A config write empties the
// window.
module sliding_window_trimmed_mean_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] mean_valid, [16:1] trimmed_mean, zero fill
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import swtm_pkg::*;

    logic [LenBits-1:0]  len_reg;
    logic [TrimBits-1:0] trim_reg;
    logic [CountBits-1:0] win, trim;
    logic                busy_reg, busy_next;
    logic                start, win_done, win_full, div_done;
    logic [SumBits-1:0]  sum;
    logic [SampleBits-1:0] quo;
    div_req_t            req;
    logic                ovalid_reg, ovalid_next;
    logic [16:0]         odata_reg, odata_next;

    // Clamp window length and trim
    always_comb
    begin
        win = (len_reg < 7'd3) ? CountBits'(3) :
              (len_reg > 7'(WindowMax)) ? CountBits'(WindowMax) : CountBits'(len_reg);
        trim = (CountBits'(trim_reg) > ((win - 1'b1) >> 1)) ? ((win - 1'b1) >> 1)
                                                             : CountBits'(trim_reg);
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= 7'd3;
            trim_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegWindowLen: len_reg  <= cfg_data;
                RegTrimCount: trim_reg <= cfg_data[TrimBits-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !busy_reg && !(ovalid_reg && !m_tready);
    assign start    = s_tvalid && s_tready;

    swtm_window u_window (
        .clk(clk), .rst_n(rst_n), .start(start), .sample(s_tdata),
        .clear(cfg_we), .win(win), .trim(trim),
        .done(win_done), .full(win_full), .sum(sum)
    );

    assign req.start    = win_done && win_full;
    assign req.dividend = sum;
    assign req.divisor  = win - (trim << 1);

    swtm_divider u_div (
        .clk(clk), .rst_n(rst_n), .req(req), .done(div_done), .quotient(quo)
    );

    // Track the item in flight, load the output register
    always_comb
    begin
        busy_next   = busy_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;
        if (start)
            busy_next = 1'b1;
        if (win_done && !win_full)
        begin
            busy_next   = 1'b0;
            ovalid_next = 1'b1;
            odata_next  = '0;
        end
        if (div_done)
        begin
            busy_next   = 1'b0;
            ovalid_next = 1'b1;
            odata_next  = {quo, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
        odata_reg <= odata_next;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'b0, odata_reg};

    // Input is never taken while an item is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_tready) else $error("accept while busy");
    // A divide result only arrives for an item in flight
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> busy_reg) else $error("stray divide result");
    // An invalid result carries a zero mean
    a_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[16:1] == 16'd0)) else $error("bad mean");
endmodule

FILE: hw/rtl/swtm_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on swtm_pkg.
module swtm_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  swtm_pkg::div_req_t         req,
    output logic                       done,
    output logic [swtm_pkg::SampleBits-1:0] quotient
);
    import swtm_pkg::*;

    localparam int StepBits = $clog2(SumBits + 1);

    logic [SumBits-1:0]   quo_reg, quo_next;
    logic [SumBits-1:0]   rem_reg, rem_next;
    logic [CountBits-1:0] dvs_reg, dvs_next;
    logic [StepBits-1:0]  step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SumBits:0]     trial;

    // Load a request, or shift in one dividend bit and try a subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[SumBits-1]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = StepBits'(SumBits);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SumBits-2:0], 1'b0};
            if (trial >= (SumBits+1)'(dvs_reg))
            begin
                rem_next    = SumBits'(trial - (SumBits+1)'(dvs_reg));
                quo_next[0] = 1'b1;
            end
            else
                rem_next = trial[SumBits-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == StepBits'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SampleBits-1:0];
endmodule

FILE: hw/rtl/swtm_window.sv
// Sample ring and sorted window in two synchronous memories, with the
// remove / insert / sum sequencer. Depends on swtm_pkg.
module swtm_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [swtm_pkg::SampleBits-1:0] sample,
    input  logic                          clear,
    input  logic [swtm_pkg::CountBits-1:0] win,
    input  logic [swtm_pkg::CountBits-1:0] trim,
    output logic                          done,
    output logic                          full,
    output logic [swtm_pkg::SumBits-1:0]  sum
);
    import swtm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RDOLD = 7'b0000010,
        S_FIND  = 7'b0000100,
        S_SHL   = 7'b0001000,
        S_SHR   = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    logic [SampleBits-1:0] ring_mem [WindowMax];
    logic [SampleBits-1:0] sort_mem [WindowMax];
    logic [SampleBits-1:0] ring_q, sort_q;

    state_t                state_reg, state_next;
    logic [CountBits-1:0]  fill_reg, fill_next;
    logic [AddrBits-1:0]   wp_reg, wp_next;
    logic [CountBits-1:0]  idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [SampleBits-1:0] samp_reg, samp_next;
    logic [SampleBits-1:0] old_reg, old_next;
    logic [SumBits-1:0]    sum_reg, sum_next;

    logic                  rd_en;
    logic [AddrBits-1:0]   rd_addr;
    logic                  wr_en;
    logic [AddrBits-1:0]   wr_addr;
    logic [SampleBits-1:0] wr_data;
    logic                  ring_we;

    // Ring memory: read oldest, write new sample
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wp_reg] <= samp_reg;
        ring_q <= ring_mem[wp_reg];
    end

    // Sorted memory: one read, one write per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            sort_mem[wr_addr] <= wr_data;
        if (rd_en)
            sort_q <= sort_mem[rd_addr];
    end

    // Sequencer. Remove walks up from 0 finding the old value, then shifts
    // the tail down; insert walks down from the top shifting up.
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        wp_next    = wp_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        samp_next  = samp_reg;
        old_next   = old_reg;
        sum_next   = sum_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AddrBits-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AddrBits-1:0];
        wr_data    = samp_reg;
        ring_we    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    samp_next = sample;
                    if ({1'b0, wp_reg} >= win)
                        wp_next = '0;
                    if (fill_reg >= win)
                    begin
                        fill_next  = win;
                        state_next = S_RDOLD;
                    end
                    else
                    begin
                        idx_next   = fill_reg;
                        state_next = S_SHR;
                    end
                end
            end
            S_RDOLD:
            begin
                // ring_q valid next cycle; begin scan at 0
                idx_next   = '0;
                rd_en      = 1'b1;
                rd_addr    = '0;
                pend_next  = 1'b1;
                state_next = S_FIND;
            end
            S_FIND:
            begin
                if (pend_reg && idx_reg == '0)
                    old_next = ring_q;
                if (sort_q == ((pend_reg && idx_reg == '0) ? ring_q : old_reg))
                begin
                    // entry idx matches: shift following entries down
                    rd_en      = 1'b1;
                    rd_addr    = AddrBits'(idx_reg + 1'b1);
                    state_next = S_SHL;
                    if (idx_reg + 1'b1 >= fill_reg)
                    begin
                        fill_next  = fill_reg - 1'b1;
                        idx_next   = fill_reg - 1'b1;
                        state_next = S_SHR;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = AddrBits'(idx_reg + 1'b1);
                end
            end
            S_SHL:
            begin
                wr_en    = 1'b1;
                wr_data  = sort_q;
                idx_next = idx_reg + 1'b1;
                rd_en    = 1'b1;
                rd_addr  = AddrBits'(idx_reg + 2'd2);
                if (idx_reg + 2'd2 >= fill_reg)
                begin
                    fill_next  = fill_reg - 1'b1;
                    idx_next   = fill_reg - 1'b1;
                    state_next = S_SHR;
                end
            end
            S_SHR:
            begin
                // idx is the hole; examine entry idx-1
                if (pend_reg)
                begin
                    if (sort_q > samp_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_data  = sort_q;
                        idx_next = idx_reg - 1'b1;
                        if (idx_reg != CountBits'(1))
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = AddrBits'(idx_reg - 2'd2);
                            pend_next = 1'b1;
                        end
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        ring_we    = 1'b1;
                        fill_next  = fill_reg + 1'b1;
                        wp_next    = ({1'b0, wp_reg} + 1'b1 >= win) ? '0 : wp_reg + 1'b1;
                        idx_next   = trim;
                        state_next = S_SUM;
                    end
                end
                else if (idx_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = AddrBits'(idx_reg - 1'b1);
                    pend_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    ring_we    = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                    wp_next    = ({1'b0, wp_reg} + 1'b1 >= win) ? '0 : wp_reg + 1'b1;
                    idx_next   = trim;
                    state_next = S_SUM;
                end
                sum_next = '0;
            end
            S_SUM:
            begin
                // read ranks trim .. win-trim-1, accumulate one behind
                if (pend_reg)
                    sum_next = sum_reg + SumBits'(sort_q);
                if (fill_reg != win)
                    state_next = S_DONE;
                else if (idx_reg < win - trim)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                    state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        if (clear)
        begin
            fill_next  = '0;
            wp_next    = '0;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            wp_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            wp_reg    <= wp_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        samp_reg <= samp_next;
        old_reg  <= old_next;
        sum_reg  <= sum_next;
    end

    assign done = (state_reg == S_DONE);
    assign full = (fill_reg == win);
    assign sum  = sum_reg;
endmodule

FILE: bench/tb_top.sv
// Testbench for the sliding-window trimmed mean block: drives samples and
// config writes, predicts each result in-bench, checks them. Needs swtm_pkg.
`timescale 1ns / 100ps

module tb_top;
    import swtm_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic        valid;
        logic [15:0] mean;
    } mean_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = RegWindowLen;
    logic [6:0]  cfg_data = '0;

    // Predictor state
    logic [6:0]  win_len_reg;
    logic [4:0]  trim_reg;
    logic [15:0] ring_q [WindowMax];
    logic [15:0] sorted_q [WindowMax];
    int          fill_cnt;
    int          wr_ptr;

    mean_result_t means_pending[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    sliding_window_trimmed_mean_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Compute the expected result for one sample and advance the window
    function automatic mean_result_t predict_mean(logic [15:0] s);
        int w, t, n, wp, pos, i, j;
        logic [21:0] sum;
        mean_result_t r;
        w = win_len_reg;
        if (w < 3) w = 3;
        if (w > WindowMax) w = WindowMax;
        t = trim_reg;
        if (t > (w - 1) / 2) t = (w - 1) / 2;
        n = fill_cnt;
        wp = wr_ptr;
        if (wp >= w) wp = 0;
        if (n > w) n = w;
        if (n >= w) begin
            for (i = 0; i < n; i++) begin
                if (sorted_q[i] == ring_q[wp]) begin
                    for (j = i; j + 1 < n; j++) sorted_q[j] = sorted_q[j + 1];
                    n--;
                    break;
                end
            end
        end
        pos = n;
        while (pos > 0 && sorted_q[pos - 1] > s) begin
            sorted_q[pos] = sorted_q[pos - 1];
            pos--;
        end
        sorted_q[pos] = s;
        n++;
        ring_q[wp] = s;
        wp++;
        if (wp >= w) wp = 0;
        fill_cnt = n;
        wr_ptr = wp;
        r = '0;
        if (n == w) begin
            sum = '0;
            for (i = t; i < w - t; i++) sum += sorted_q[i];
            r.valid = 1'b1;
            r.mean = 16'(sum / (w - 2 * t));
        end
        return r;
    endfunction

    // Timeout guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Random receiver stall
    always @(posedge clk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk) begin
        mean_result_t exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            if (means_pending.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                error_count++;
            end else begin
                exp_r = means_pending.pop_front();
                if (m_tdata[0] !== exp_r.valid) begin
                    $error("mean_valid exp %0d got %0d", exp_r.valid, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[16:1] !== exp_r.mean) begin
                    $error("trimmed_mean exp %0d got %0d", exp_r.mean, m_tdata[16:1]);
                    error_count++;
                end
            end
        end
    end

    // Send one sample, with a random gap first; valid stays up until the
    // next gap or drain drops it
    task automatic send_sample(logic [15:0] s);
        if (!no_idle) begin
            while ($urandom_range(99) < 24) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= s;
        means_pending.push_back(predict_mean(s));
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (means_pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register while the block is idle; empties the window
    task automatic write_reg(logic [0:0] idx, logic [6:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == RegWindowLen) win_len_reg = val;
        else trim_reg = val[4:0];
        fill_cnt = 0;
        wr_ptr = 0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(3))
            0: return 16'($urandom_range(3));
            1: return 16'hFFFF - 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    // Reset defaults, extremes and duplicate values
    task automatic test_directed();
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        // Maximum window, trim zero averages all
        write_reg(RegWindowLen, 7'd64);
        write_reg(RegTrimCount, 7'd0);
        for (int i = 0; i < 66; i++) send_sample(16'hFFFF);
    endtask

    // Many settings: clamps below 3 and above 64, trim too large
    task automatic test_config_sweep();
        logic [6:0] lens [6] = '{7'd0, 7'd3, 7'd127, 7'd5, 7'd64, 7'd100};
        logic [4:0] trims [6] = '{5'd31, 5'd1, 5'd0, 5'd2, 5'd31, 5'd10};
        for (int k = 0; k < 6; k++) begin
            write_reg(RegWindowLen, lens[k]);
            write_reg(RegTrimCount, 7'(trims[k]));
            for (int i = 0; i < 80; i++) send_sample(rand_sample());
        end
    endtask

    // Random windows, mostly small; pause on drain once per phase
    task automatic test_random();
        for (int ph = 0; ph < 14; ph++) begin
            write_reg(RegWindowLen, (ph % 5 == 0) ? 7'($urandom) :
                      7'($urandom_range(3, 12)));
            write_reg(RegTrimCount, 7'($urandom_range(31)));
            no_idle = (ph == 6);
            for (int i = 0; i < 80; i++) begin
                send_sample(($urandom_range(3) == 0) ? 16'($urandom_range(7)) :
                            rand_sample());
                if (i == 40) wait_drained();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        win_len_reg = 7'd3;
        trim_reg = 5'd1;
        fill_cnt = 0;
        wr_ptr = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random();
        wait_drained();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/swtm_pkg.sv
hw/rtl/swtm_divider.sv
hw/rtl/swtm_window.sv
hw/rtl/sliding_window_trimmed_mean_top.sv
bench/tb_top.sv
